FILE: rtl/ubx_fr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UBX frame receiver package
// Shared types, constants and codes for the UBX frame receiver.
// ----------------------------------------------------------------------------
package ubx_fr_pkg;

    localparam int MAX_PAYLOAD = 512;
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_GOOD    = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] CFG_CHECK_B     = 2'd2;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SYNC,
        PH_CLASS,
        PH_ID,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD,
        PH_CHK_B
    } phase_t;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic       check_b_enable;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [9:0]  payload_len;
        logic [7:0]  data_byte;
        logic [8:0]  byte_index;
        logic        frame_end;
        logic [15:0] good_count;
        logic [15:0] error_count;
    } result_t;

endpackage

FILE: rtl/ubx_fr_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UBX frame parser
// Frame state machine, running Fletcher sum and frame counters; forms the
// result for each accepted payload or checksum B byte in the same cycle.
// ----------------------------------------------------------------------------
module ubx_fr_parser
    import ubx_fr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       take,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    output result_t    res
);

    phase_t            phase_reg, phase_next;
    logic [7:0]        class_reg, class_next;
    logic [7:0]        id_reg, id_next;
    logic [7:0]        len_lo_reg, len_lo_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic [7:0]        sum_a_reg, sum_a_next;
    logic [7:0]        sum_b_reg, sum_b_next;
    logic [7:0]        recv_a_reg, recv_a_next;
    logic [15:0]       good_reg, good_next;
    logic [15:0]       bad_reg, bad_next;

    logic [15:0]       len_raw;
    logic [LEN_W-1:0]  len_clamped;
    logic              payload_done;
    logic              frame_good;
    logic [7:0]        fold_a;
    logic [7:0]        fold_b;
    logic              do_fold;

    assign len_raw      = {rx_byte, len_lo_reg};
    assign len_clamped  = (32'(len_raw) >= MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD)
                                                        : LEN_W'(len_raw);
    assign payload_done = (count_reg >= len_reg);
    assign frame_good   = (recv_a_reg == sum_a_reg)
                          && (!cfg.check_b_enable || (rx_byte == sum_b_reg));

    // The class byte restarts the sum from zero.
    assign fold_a = ((phase_reg == PH_CLASS) ? 8'd0 : sum_a_reg) + rx_byte;
    assign fold_b = ((phase_reg == PH_CLASS) ? 8'd0 : sum_b_reg) + fold_a;

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == cfg.sync_first)
                begin
                    phase_next = PH_SYNC;
                end
            end
            PH_SYNC:    phase_next = (rx_byte == cfg.sync_second) ? PH_CLASS : PH_HUNT;
            PH_CLASS:   phase_next = PH_ID;
            PH_ID:      phase_next = PH_LEN_LO;
            PH_LEN_LO:  phase_next = PH_LEN_HI;
            PH_LEN_HI:  phase_next = PH_PAYLOAD;
            PH_PAYLOAD:
            begin
                if (payload_done)
                begin
                    phase_next = PH_CHK_B;
                end
            end
            PH_CHK_B:   phase_next = PH_HUNT;
            default:    phase_next = PH_HUNT;
        endcase
    end

    always_comb
    begin
        do_fold   = 1'b0;
        res_valid = 1'b0;
        unique case (phase_reg)
            PH_CLASS, PH_ID, PH_LEN_LO, PH_LEN_HI:
            begin
                do_fold = 1'b1;
            end
            PH_PAYLOAD:
            begin
                do_fold   = !payload_done;
                res_valid = !payload_done;
            end
            PH_CHK_B:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                do_fold   = 1'b0;
                res_valid = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        class_next  = class_reg;
        id_next     = id_reg;
        len_lo_next = len_lo_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        sum_a_next  = sum_a_reg;
        sum_b_next  = sum_b_reg;
        recv_a_next = recv_a_reg;
        good_next   = good_reg;
        bad_next    = bad_reg;
        if (do_fold)
        begin
            sum_a_next = fold_a;
            sum_b_next = fold_b;
        end
        unique case (phase_reg)
            PH_CLASS:   class_next  = rx_byte;
            PH_ID:      id_next     = rx_byte;
            PH_LEN_LO:
            begin
                len_lo_next = rx_byte;
                len_next    = LEN_W'(rx_byte);
            end
            PH_LEN_HI:
            begin
                len_next   = len_clamped;
                count_next = '0;
            end
            PH_PAYLOAD:
            begin
                if (payload_done)
                begin
                    recv_a_next = rx_byte;
                end
                else
                begin
                    count_next = count_reg + LEN_W'(1);
                end
            end
            PH_CHK_B:
            begin
                if (frame_good)
                begin
                    if (good_reg != 16'hFFFF)
                    begin
                        good_next = good_reg + 16'd1;
                    end
                end
                else if (bad_reg != 16'hFFFF)
                begin
                    bad_next = bad_reg + 16'd1;
                end
            end
            default:
            begin
                class_next = class_reg;
            end
        endcase
    end

    always_comb
    begin
        res.msg_class   = class_reg;
        res.msg_id      = id_reg;
        res.payload_len = 10'(len_reg);
        res.good_count  = good_next;
        res.error_count = bad_next;
        if (phase_reg == PH_CHK_B)
        begin
            res.kind       = frame_good ? KIND_GOOD : KIND_ERROR;
            res.data_byte  = 8'd0;
            res.byte_index = 9'd0;
            res.frame_end  = 1'b1;
        end
        else
        begin
            res.kind       = KIND_PAYLOAD;
            res.data_byte  = rx_byte;
            res.byte_index = 9'(count_reg);
            res.frame_end  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            class_reg  <= '0;
            id_reg     <= '0;
            len_lo_reg <= '0;
            len_reg    <= '0;
            count_reg  <= '0;
            sum_a_reg  <= '0;
            sum_b_reg  <= '0;
            recv_a_reg <= '0;
            good_reg   <= '0;
            bad_reg    <= '0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            class_reg  <= class_next;
            id_reg     <= id_next;
            len_lo_reg <= len_lo_next;
            len_reg    <= len_next;
            count_reg  <= count_next;
            sum_a_reg  <= sum_a_next;
            sum_b_reg  <= sum_b_next;
            recv_a_reg <= recv_a_next;
            good_reg   <= good_next;
            bad_reg    <= bad_next;
        end
    end

    // The clamped length never exceeds the maximum payload.
    a_len_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        32'(len_reg) <= MAX_PAYLOAD)
        else $error("stored payload length above maximum");

    // The payload byte count never exceeds the stored length.
    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> count_reg <= len_reg)
        else $error("payload index beyond length");

    // A frame end always returns the parser to sync hunting.
    a_end_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (take && res_valid && res.frame_end) |=> phase_reg == PH_HUNT)
        else $error("parser did not return to hunting after frame end");

    // Exactly one counter moves on a frame end while neither counter is saturated.
    a_one_count: assert property (@(posedge clk) disable iff (!rst_n)
        (take && phase_reg == PH_CHK_B && good_reg != 16'hFFFF && bad_reg != 16'hFFFF)
        |=> ((good_reg != $past(good_reg)) != (bad_reg != $past(bad_reg))))
        else $error("frame end did not update exactly one counter");

endmodule

FILE: rtl/ubx_fr_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UBX frame receiver output buffer
// Output register with one skid entry, so the input side keeps moving while
// a result waits on the output.
// ----------------------------------------------------------------------------
module ubx_fr_outbuf
    import ubx_fr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    space,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;

    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || out_ready)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= push;
                end
            end
            else if (push)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (push)
            begin
                out_data_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

    // The skid entry is only filled behind a waiting output word.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output word");

    // A waiting skid word moves to the output when the output is taken.
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid entry did not move to the output");

    // No word is pushed while both entries are full.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push)
        else $error("push into a full output buffer");

endmodule

FILE: rtl/ubx_frame_receiver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UBX frame receiver
// Deframes UBX messages from a byte stream and checks the Fletcher checksum.
// ----------------------------------------------------------------------------
// Usage:
// Received bytes enter on the input channel (in_valid, in_ready, rx_byte),
// one word per cycle at full rate. Sync, header, length and checksum A
// bytes produce no result. Each payload byte and each checksum B byte
// produces one result word on the output channel (out_valid, out_ready and
// the result fields), registered in the output register or, on a stall, in
// the skid entry; the block sustains one word per cycle while out_ready is
// high. The output register plus one skid entry let the input keep flowing
// for one word while the output is stalled; in_ready drops only while the
// skid entry is occupied, and rises in the cycle after the receiver resumes.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; index 0 sets the first sync byte, 1 the second sync byte,
// 2 the checksum B enable, and other indexes are ignored.
// Reset restores the default sync bytes 0xB5 and 0x62, enables the B check,
// clears both frame counters and starts hunting for sync with an empty
// output.
// ----------------------------------------------------------------------------
module ubx_frame_receiver_top
    import ubx_fr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  msg_class,
    output logic [7:0]  msg_id,
    output logic [9:0]  payload_len,
    output logic [7:0]  data_byte,
    output logic [8:0]  byte_index,
    output logic        frame_end,
    output logic [15:0] good_count,
    output logic [15:0] error_count
);

    cfg_t    cfg_reg;
    logic    take;
    logic    res_valid;
    result_t res;
    result_t out_data;
    logic    space;

    assign cfg_ready = 1'b1;
    assign in_ready  = space;
    assign take      = in_valid && space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first     <= 8'd181;
            cfg_reg.sync_second    <= 8'd98;
            cfg_reg.check_b_enable <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SYNC_FIRST:  cfg_reg.sync_first     <= cfg_data;
                CFG_SYNC_SECOND: cfg_reg.sync_second    <= cfg_data;
                CFG_CHECK_B:     cfg_reg.check_b_enable <= cfg_data[0];
                default:         cfg_reg                <= cfg_reg;
            endcase
        end
    end

    ubx_fr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .take      (take),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    ubx_fr_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take && res_valid),
        .push_data (res),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign kind        = out_data.kind;
    assign msg_class   = out_data.msg_class;
    assign msg_id      = out_data.msg_id;
    assign payload_len = out_data.payload_len;
    assign data_byte   = out_data.data_byte;
    assign byte_index  = out_data.byte_index;
    assign frame_end   = out_data.frame_end;
    assign good_count  = out_data.good_count;
    assign error_count = out_data.error_count;

endmodule

FILE: tb/ubx_frame_receiver_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UBX frame receiver testbench
// Streams received bytes into the deframer and checks every result word
// against a cycle-free model of the sync hunt, header capture, payload
// indexing, Fletcher checksum and saturating frame counters. The traffic
// covers directed corner frames, random frames with damaged checksums and
// line noise under several register settings, back-pressure on both sides,
// and a final full-rate run of short good and damaged frames.
// ----------------------------------------------------------------------------
module ubx_frame_receiver_top_test;
    import ubx_fr_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned DRAIN_LIMIT = 100000;
    localparam int unsigned PHASE_ITEMS = 80;
    localparam int TIMEOUT_NS = 10_000_000;

    typedef enum logic [1:0] {
        DAMAGE_NONE,
        DAMAGE_A,
        DAMAGE_B,
        DAMAGE_BOTH
    } damage_t;

    class ubx_frame_checker;
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic check_b;
        phase_t parse_st;
        logic [7:0] cls;
        logic [7:0] id;
        logic [15:0] frame_len;
        logic [15:0] count;
        logic [7:0] sum_a;
        logic [7:0] sum_b;
        logic [7:0] recv_a;
        logic [15:0] good_n;
        logic [15:0] bad_n;
        result_t pending_results[$];
        int unsigned fail_count;

        function new();
            sync_first = 8'hB5;
            sync_second = 8'h62;
            check_b = 1'b1;
            parse_st = PH_HUNT;
            cls = 8'h00;
            id = 8'h00;
            frame_len = 16'h0000;
            count = 16'h0000;
            sum_a = 8'h00;
            sum_b = 8'h00;
            recv_a = 8'h00;
            good_n = 16'h0000;
            bad_n = 16'h0000;
            fail_count = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [7:0] data);
            case (idx)
                CFG_SYNC_FIRST: sync_first = data;
                CFG_SYNC_SECOND: sync_second = data;
                CFG_CHECK_B: check_b = data[0];
                default: ;
            endcase
        endfunction

        function void fold(logic [7:0] b);
            sum_a = sum_a + b;
            sum_b = sum_b + sum_a;
        endfunction

        function void queue_result(logic [1:0] k, logic [7:0] data, logic [8:0] idx,
                                   logic last);
            result_t r;
            r.kind = k;
            r.msg_class = cls;
            r.msg_id = id;
            r.payload_len = frame_len[9:0];
            r.data_byte = data;
            r.byte_index = idx;
            r.frame_end = last;
            r.good_count = good_n;
            r.error_count = bad_n;
            pending_results.push_back(r);
        endfunction

        function void take_rx_byte(logic [7:0] b);
            logic good;
            case (parse_st)
                PH_HUNT:
                begin
                    if (b == sync_first)
                        parse_st = PH_SYNC;
                end
                PH_SYNC:
                begin
                    parse_st = (b == sync_second) ? PH_CLASS : PH_HUNT;
                end
                PH_CLASS:
                begin
                    cls = b;
                    sum_a = 8'h00;
                    sum_b = 8'h00;
                    fold(b);
                    parse_st = PH_ID;
                end
                PH_ID:
                begin
                    id = b;
                    fold(b);
                    parse_st = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    frame_len = {8'h00, b};
                    fold(b);
                    parse_st = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    frame_len = {b, frame_len[7:0]};
                    fold(b);
                    if (frame_len >= 16'(MAX_PAYLOAD))
                        frame_len = 16'(MAX_PAYLOAD);
                    count = 16'h0000;
                    parse_st = PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    if (count >= frame_len)
                    begin
                        recv_a = b;
                        parse_st = PH_CHK_B;
                    end
                    else
                    begin
                        fold(b);
                        queue_result(KIND_PAYLOAD, b, count[8:0], 1'b0);
                        count = count + 16'd1;
                    end
                end
                default:
                begin
                    good = (recv_a == sum_a) && (!check_b || b == sum_b);
                    if (good)
                    begin
                        if (good_n != 16'hFFFF)
                            good_n = good_n + 16'd1;
                    end
                    else
                    begin
                        if (bad_n != 16'hFFFF)
                            bad_n = bad_n + 16'd1;
                    end
                    parse_st = PH_HUNT;
                    queue_result(good ? KIND_GOOD : KIND_ERROR, 8'h00, 9'h000, 1'b1);
                end
            endcase
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                fail_count++;
                $error("%s: expected %0h, got %0h", name, want, got);
            end
        endfunction

        function void compare_result(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                fail_count++;
                $error("result word with no expectation, kind %0h", got.kind);
                return;
            end
            want = pending_results.pop_front();
            check_field("kind", 16'(want.kind), 16'(got.kind));
            check_field("msg_class", 16'(want.msg_class), 16'(got.msg_class));
            check_field("msg_id", 16'(want.msg_id), 16'(got.msg_id));
            check_field("payload_len", 16'(want.payload_len), 16'(got.payload_len));
            check_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
            check_field("byte_index", 16'(want.byte_index), 16'(got.byte_index));
            check_field("frame_end", 16'(want.frame_end), 16'(got.frame_end));
            check_field("good_count", want.good_count, got.good_count);
            check_field("error_count", want.error_count, got.error_count);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [9:0]  payload_len;
    logic [7:0]  data_byte;
    logic [8:0]  byte_index;
    logic        frame_end;
    logic [15:0] good_count;
    logic [15:0] error_count;

    ubx_frame_checker frame_chk = new();
    int unsigned items_sent = 0;
    int unsigned send_idle_odds = 0;
    int unsigned sink_idle_odds = 0;
    bit hold_req = 1'b0;

    ubx_frame_receiver_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .kind(kind),
        .msg_class(msg_class),
        .msg_id(msg_id),
        .payload_len(payload_len),
        .data_byte(data_byte),
        .byte_index(byte_index),
        .frame_end(frame_end),
        .good_count(good_count),
        .error_count(error_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_byte(input logic [7:0] value);
        if (send_idle_odds != 0 && $urandom_range(1, send_idle_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= value;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        frame_chk.take_rx_byte(value);
        items_sent++;
    endtask

    task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                              input logic [15:0] raw_len, input damage_t dmg);
        logic [7:0] body[$];
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        int unsigned n;
        n = (raw_len >= 16'(MAX_PAYLOAD)) ? MAX_PAYLOAD : int'(raw_len);
        body = {cls, id, raw_len[7:0], raw_len[15:8]};
        repeat (n) body.push_back(8'($urandom));
        ck_a = 8'h00;
        ck_b = 8'h00;
        foreach (body[i])
        begin
            ck_a = ck_a + body[i];
            ck_b = ck_b + ck_a;
        end
        if (dmg == DAMAGE_A || dmg == DAMAGE_BOTH)
            ck_a = ck_a ^ 8'($urandom_range(1, 255));
        if (dmg == DAMAGE_B || dmg == DAMAGE_BOTH)
            ck_b = ck_b ^ 8'($urandom_range(1, 255));
        send_byte(frame_chk.sync_first);
        send_byte(frame_chk.sync_second);
        foreach (body[i])
            send_byte(body[i]);
        send_byte(ck_a);
        send_byte(ck_b);
    endtask

    task automatic random_traffic(input int unsigned budget);
        int unsigned start;
        int unsigned pick;
        logic [15:0] len;
        logic [7:0] b;
        damage_t dmg;
        start = items_sent;
        while (items_sent - start < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 85)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    len = 16'($urandom_range(0, 12));
                else if (pick < 95)
                    len = 16'($urandom_range(13, 80));
                else if (pick < 99)
                    len = 16'($urandom_range(81, 300));
                else
                    len = 16'($urandom_range(512, 65535));
                case ($urandom_range(0, 9))
                    0: dmg = DAMAGE_A;
                    1: dmg = DAMAGE_B;
                    2: dmg = DAMAGE_BOTH;
                    default: dmg = DAMAGE_NONE;
                endcase
                send_frame(8'($urandom), 8'($urandom), len, dmg);
            end
            else if (pick < 93)
            begin
                repeat ($urandom_range(1, 8))
                begin
                    do b = 8'($urandom); while (b == frame_chk.sync_first);
                    send_byte(b);
                end
            end
            else
            begin
                send_byte(frame_chk.sync_first);
                if ($urandom_range(0, 1) == 1 && frame_chk.sync_first != frame_chk.sync_second)
                    b = frame_chk.sync_first;
                else
                    do b = 8'($urandom); while (b == frame_chk.sync_second);
                send_byte(b);
            end
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (frame_chk.pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] first_byte, input logic [7:0] second_byte,
                             input logic check_b);
        logic [1:0] idx[4];
        logic [7:0] val[4];
        idx = '{CFG_SYNC_FIRST, CFG_SYNC_SECOND, CFG_CHECK_B, CFG_UNUSED};
        val = '{first_byte, second_byte, {7'($urandom), check_b}, 8'($urandom)};
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            frame_chk.write_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : result_sink
        result_t got;
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left = 0;
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got = {kind, msg_class, msg_id, payload_len, data_byte, byte_index,
                       frame_end, good_count, error_count};
                frame_chk.compare_result(got);
            end
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left != 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (sink_idle_odds != 0 && $urandom_range(1, sink_idle_odds) == 1)
            begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(0, 15);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned waited;
        in_valid <= 1'b0;
        rx_byte <= 8'h00;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_SYNC_FIRST;
        cfg_data <= 8'h00;
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A repeated first sync byte must drop back to hunting, not restart.
        send_idle_odds = 4;
        sink_idle_odds = 4;
        send_byte(frame_chk.sync_first);
        send_byte(frame_chk.sync_first);
        send_byte(frame_chk.sync_first);
        send_byte(8'h07);
        send_frame(8'h00, 8'hFF, 16'd0, DAMAGE_NONE);
        send_frame(8'hFF, 8'h00, 16'd1, DAMAGE_B);
        send_frame(8'($urandom), 8'($urandom), 16'hFFFF, DAMAGE_NONE);
        random_traffic(PHASE_ITEMS);
        wait_idle();

        // Stall the output long enough for the input side to back up.
        configure(8'h00, 8'hFF, 1'b0);
        send_idle_odds = 0;
        sink_idle_odds = 6;
        hold_req = 1'b1;
        send_frame(8'($urandom), 8'($urandom), 16'd48, DAMAGE_B);
        send_idle_odds = 3;
        random_traffic(PHASE_ITEMS);
        wait_idle();

        configure(8'hFF, 8'h00, 1'b1);
        send_idle_odds = 0;
        sink_idle_odds = 0;
        send_frame(8'($urandom), 8'($urandom), 16'h0200, DAMAGE_NONE);
        random_traffic(PHASE_ITEMS);
        wait_idle();

        configure(8'($urandom), 8'($urandom), 1'($urandom));
        send_idle_odds = 8;
        sink_idle_odds = 2;
        random_traffic(PHASE_ITEMS / 2);
        wait_idle();
        random_traffic(PHASE_ITEMS / 2);
        wait_idle();

        configure(8'h5A, 8'h5A, 1'b0);
        send_idle_odds = 2;
        sink_idle_odds = 8;
        random_traffic(PHASE_ITEMS);
        wait_idle();

        // Full-rate empty frames, first good and then with a damaged checksum A.
        configure(8'hB5, 8'h62, 1'b1);
        send_idle_odds = 0;
        sink_idle_odds = 0;
        repeat (4) send_frame(8'($urandom), 8'($urandom), 16'd0, DAMAGE_NONE);
        repeat (4) send_frame(8'($urandom), 8'($urandom), 16'd0, DAMAGE_A);
        send_frame(8'($urandom), 8'($urandom), 16'd3, DAMAGE_NONE);

        in_valid <= 1'b0;
        for (waited = 0; waited < DRAIN_LIMIT && frame_chk.pending_results.size() != 0;
             waited++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (frame_chk.pending_results.size() != 0)
        begin
            $error("%0d expected result words never arrived",
                   frame_chk.pending_results.size());
            frame_chk.fail_count += frame_chk.pending_results.size();
        end
        if (frame_chk.fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: ubx_frame_receiver_top.f
rtl/ubx_fr_pkg.sv
rtl/ubx_fr_parser.sv
rtl/ubx_fr_outbuf.sv
rtl/ubx_frame_receiver_top.sv
tb/ubx_frame_receiver_top_test.sv
